// File: sv/otl_pkg.sv
`default_nettype none
package otl_pkg;

   // Table entry codes: 1..20 are next states, GOOD ends the token on this
   // byte, BACK_UP ends the token before this byte
   typedef logic [6:0] code_type;
   typedef logic [4:0] state_type;
   typedef logic [4:0] class_type;

   localparam code_type  CODE_GOOD    = 7'd101;
   localparam code_type  CODE_BACK_UP = 7'd102;
   localparam code_type  CODE_FINAL   = 7'd100;
   localparam state_type STATE_IDLE   = 5'd0;
   localparam state_type STATE_LAST   = 5'd20;
   localparam logic [7:0] BYTE_SEMI   = 8'h3B;

   // Character classes
   localparam class_type CLS_ALPHA = 5'd0;
   localparam class_type CLS_DIGIT = 5'd1;
   localparam class_type CLS_UNDER = 5'd2;
   localparam class_type CLS_PLUS  = 5'd3;
   localparam class_type CLS_EQ    = 5'd4;
   localparam class_type CLS_PCT   = 5'd5;
   localparam class_type CLS_AMP   = 5'd6;
   localparam class_type CLS_STAR  = 5'd7;
   localparam class_type CLS_RBRK  = 5'd8;
   localparam class_type CLS_LBRK  = 5'd9;
   localparam class_type CLS_RPAR  = 5'd10;
   localparam class_type CLS_LPAR  = 5'd11;
   localparam class_type CLS_DOT   = 5'd12;
   localparam class_type CLS_SLASH = 5'd13;
   localparam class_type CLS_QUES  = 5'd14;
   localparam class_type CLS_BANG  = 5'd15;
   localparam class_type CLS_COLON = 5'd16;
   localparam class_type CLS_COMMA = 5'd17;
   localparam class_type CLS_MINUS = 5'd18;
   localparam class_type CLS_GT    = 5'd19;
   localparam class_type CLS_BAR   = 5'd20;
   localparam class_type CLS_LT    = 5'd21;
   localparam class_type CLS_TILDE = 5'd22;
   localparam class_type CLS_CARET = 5'd23;
   localparam class_type CLS_NONE  = 5'd24;

   // One queue entry: up to two results of one input byte
   typedef struct packed {
      logic [1:0] count;
      logic [7:0] byte0;
      logic       end0;
      logic [7:0] byte1;
      logic       end1;
   } entry_type;

   function automatic class_type class_of(input logic [7:0] b);
      class_type c;
      c = CLS_NONE;
      case (b) inside
         [8'h61:8'h7A], [8'h41:8'h5A]: c = CLS_ALPHA;
         [8'h30:8'h39]: c = CLS_DIGIT;
         8'h5F: c = CLS_UNDER;
         8'h2B: c = CLS_PLUS;
         8'h3D: c = CLS_EQ;
         8'h25: c = CLS_PCT;
         8'h26: c = CLS_AMP;
         8'h2A: c = CLS_STAR;
         8'h5D: c = CLS_RBRK;
         8'h5B: c = CLS_LBRK;
         8'h29: c = CLS_RPAR;
         8'h28: c = CLS_LPAR;
         8'h2E: c = CLS_DOT;
         8'h2F: c = CLS_SLASH;
         8'h3F: c = CLS_QUES;
         8'h21: c = CLS_BANG;
         8'h3A: c = CLS_COLON;
         8'h2C: c = CLS_COMMA;
         8'h2D: c = CLS_MINUS;
         8'h3E: c = CLS_GT;
         8'h7C: c = CLS_BAR;
         8'h3C: c = CLS_LT;
         8'h7E: c = CLS_TILDE;
         8'h5E: c = CLS_CARET;
         default: c = CLS_NONE;
      endcase
      return c;
   endfunction

   // Transition table, row 0: first byte of a token
   function automatic code_type start_code(input class_type c);
      code_type r;
      r = CODE_GOOD;
      unique case (c) inside
         CLS_ALPHA, CLS_UNDER: r = 7'd1;
         CLS_DIGIT: r = 7'd2;
         CLS_PLUS:  r = 7'd5;
         CLS_EQ:    r = 7'd19;
         CLS_PCT:   r = 7'd10;
         CLS_AMP:   r = 7'd11;
         CLS_STAR:  r = 7'd6;
         CLS_DOT:   r = 7'd4;
         CLS_SLASH: r = 7'd14;
         CLS_BANG:  r = 7'd15;
         CLS_COLON: r = 7'd16;
         CLS_MINUS: r = 7'd17;
         CLS_GT:    r = 7'd12;
         CLS_BAR:   r = 7'd18;
         CLS_LT:    r = 7'd7;
         CLS_CARET: r = 7'd20;
         default:   r = CODE_GOOD;
      endcase
      return r;
   endfunction

   // Transition table, all rows; unlisted entries back up, except in row 0 where they are GOOD
   function automatic code_type next_code(input state_type s, input class_type c);
      code_type r;
      r = CODE_BACK_UP;
      unique case (s) inside
         5'd0: r = start_code(c);
         5'd1: if (c == CLS_ALPHA || c == CLS_DIGIT || c == CLS_UNDER) r = 7'd1;
         5'd2: begin
            if (c == CLS_DIGIT) r = 7'd2;
            if (c == CLS_DOT) r = 7'd3;
         end
         5'd3, 5'd4: if (c == CLS_DIGIT) r = 7'd4;
         5'd5: begin
            if (c == CLS_DIGIT) r = 7'd2;
            if (c == CLS_PLUS || c == CLS_EQ) r = CODE_GOOD;
            if (c == CLS_DOT) r = 7'd4;
         end
         5'd6: if (c == CLS_EQ) r = CODE_GOOD;
         5'd7: begin
            if (c == CLS_EQ) r = 7'd8;
            if (c == CLS_LT) r = 7'd9;
         end
         5'd8: if (c == CLS_GT) r = CODE_GOOD;
         5'd9, 5'd10, 5'd13, 5'd14, 5'd15, 5'd19, 5'd20:
            if (c == CLS_EQ) r = CODE_GOOD;
         5'd11: if (c == CLS_EQ || c == CLS_AMP) r = CODE_GOOD;
         5'd12: begin
            if (c == CLS_EQ) r = CODE_GOOD;
            if (c == CLS_GT) r = 7'd13;
         end
         5'd16: if (c == CLS_COLON) r = CODE_GOOD;
         5'd17: begin
            if (c == CLS_DIGIT) r = 7'd2;
            if (c == CLS_DOT) r = 7'd4;
            if (c == CLS_EQ || c == CLS_MINUS || c == CLS_GT) r = CODE_GOOD;
         end
         5'd18: if (c == CLS_EQ || c == CLS_BAR) r = CODE_GOOD;
         default: r = CODE_BACK_UP;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// File: sv/otl_channels_if.sv
`default_nettype none
interface otl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] source_byte;
   modport source(output valid, output source_byte, input ready);
   modport sink(input valid, input source_byte, output ready);
endinterface

interface otl_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] token_byte;
   logic       token_end;
   logic       run_end;
   modport source(output valid, output token_byte, output token_end, output run_end,
                  input ready);
   modport sink(input valid, input token_byte, input token_end, input run_end,
                output ready);
endinterface
`default_nettype wire

// File: sv/otl_front.sv
`default_nettype none
module otl_front
   import otl_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   otl_req_if.sink    req_if,
   input  wire logic  queue_full,
   output logic       push,
   output entry_type  push_entry
);

   state_type  lex_state_ff, lex_state_in;
   logic [7:0] held_byte_ff, held_byte_in;
   logic       held_valid_ff, held_valid_in;

   logic       accept;
   class_type  cls;
   logic       unclassed;
   state_type  cur_state;
   code_type   held_code;
   code_type   fresh_code;
   logic       fresh_emit;
   logic       fresh_hold;
   logic [7:0] b;

   assign req_if.ready = !queue_full && !reset;
   assign accept       = req_if.valid && req_if.ready;
   assign b            = req_if.source_byte;

   // Classify and look up both the running and the fresh transition
   always_comb begin
      cls        = class_of(b);
      unclassed  = (cls == CLS_NONE);
      cur_state  = (lex_state_ff > STATE_LAST) ? STATE_IDLE : lex_state_ff;
      held_code  = unclassed ? CODE_BACK_UP : next_code(cur_state, cls);
      fresh_code = unclassed ? CODE_BACK_UP : next_code(STATE_IDLE, cls);
      fresh_emit = unclassed ? (b == BYTE_SEMI) : (fresh_code > CODE_FINAL);
      fresh_hold = !unclassed && (fresh_code < CODE_FINAL);
   end

   // Build the results of this byte and the next lexer state
   always_comb begin
      push_entry    = '0;
      lex_state_in  = lex_state_ff;
      held_byte_in  = held_byte_ff;
      held_valid_in = held_valid_ff;
      if (held_valid_ff && held_code != CODE_BACK_UP) begin
         push_entry.byte0 = held_byte_ff;
         push_entry.end0  = 1'b0;
         if (held_code > CODE_FINAL) begin
            push_entry.byte1 = b;
            push_entry.end1  = 1'b1;
            push_entry.count = 2'd2;
            lex_state_in     = STATE_IDLE;
            held_byte_in     = '0;
            held_valid_in    = 1'b0;
         end else begin
            push_entry.count = 2'd1;
            lex_state_in     = held_code[4:0];
            held_byte_in     = b;
            held_valid_in    = 1'b1;
         end
      end else begin
         if (held_valid_ff) begin
            push_entry.byte0 = held_byte_ff;
            push_entry.end0  = 1'b1;
            if (fresh_emit) begin
               push_entry.byte1 = b;
               push_entry.end1  = 1'b1;
               push_entry.count = 2'd2;
            end else begin
               push_entry.count = 2'd1;
            end
         end else if (fresh_emit) begin
            push_entry.byte0 = b;
            push_entry.end0  = 1'b1;
            push_entry.count = 2'd1;
         end
         held_valid_in = fresh_hold;
         lex_state_in  = fresh_hold ? fresh_code[4:0] : STATE_IDLE;
         held_byte_in  = fresh_hold ? b : 8'd0;
      end
   end

   assign push = accept && (push_entry.count != 2'd0);

   // Advance the lexer on each input transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         lex_state_ff  <= STATE_IDLE;
         held_byte_ff  <= '0;
         held_valid_ff <= 1'b0;
      end else if (accept) begin
         lex_state_ff  <= lex_state_in;
         held_byte_ff  <= held_byte_in;
         held_valid_ff <= held_valid_in;
      end
   end

endmodule
`default_nettype wire

// File: sv/otl_queue.sv
`default_nettype none
module otl_queue
   import otl_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire entry_type  push_entry,
   input  wire logic       pop,
   output logic            full,
   output logic            not_empty,
   output entry_type       head
);

   entry_type  slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_entry;
   end

   // Track pointers and fill
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

// File: sv/otl_back.sv
`default_nettype none
module otl_back
   import otl_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       not_empty,
   input  wire entry_type  head,
   output logic            pop,
   otl_rsp_if.source       rsp_if
);

   logic       sel_ff, sel_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       end_ff;
   logic       run_end_ff;
   logic       load;
   logic       last;

   // Load the output register when it is empty or being taken
   assign load = not_empty && (!valid_ff || rsp_if.ready);
   assign last = sel_ff || (head.count == 2'd1);
   assign pop  = load && last;

   always_comb begin
      sel_in   = sel_ff;
      valid_in = valid_ff;
      if (load) begin
         sel_in   = !last;
         valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         sel_ff   <= sel_in;
         valid_ff <= valid_in;
      end
   end

   // Hold the result payload until its transfer
   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff    <= sel_ff ? head.byte1 : head.byte0;
         end_ff     <= sel_ff ? head.end1 : head.end0;
         run_end_ff <= last;
      end
   end

   assign rsp_if.valid      = valid_ff;
   assign rsp_if.token_byte = byte_ff;
   assign rsp_if.token_end  = end_ff;
   assign rsp_if.run_end    = run_end_ff;

endmodule
`default_nettype wire

// File: sv/operator_token_lexer_core.sv
// Operator token lexer.
// req_if carries one source byte per transfer; rsp_if carries token bytes,
// each with token_end (last byte of its token) and run_end (last result of
// the source byte that caused it). A source byte gives zero, one or two
// results; whitespace and unclassed bytes but ';' only close a held token.
// The front end classifies a byte and steps the transition table in the
// cycle of its transfer, then writes its results into a two-entry queue.
// The back end drains the queue into a registered output, one result per
// cycle while results are taken; the first result of a byte passes through
// the queue, then the output register, before it is presented.
// Throughput: one source byte per cycle while results are taken;
// a byte with two results occupies the output for both in turn, so the
// sustained input rate is bounded by one result per cycle at rsp_if.
// The last byte of a multi-byte token stays held in the lexer until the
// following byte shows where the token ends.
// Reset clears the lexer state, the queue and the output valid, and holds
// req_if.ready low while it is asserted.
// When the receiver stalls the output holds; the queue takes up to two more
// bytes that give results, then req_if.ready drops until space frees.
`default_nettype none
module operator_token_lexer_core
   import otl_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   otl_req_if.sink    req_if,
   otl_rsp_if.source  rsp_if
);

   logic      push;
   entry_type push_entry;
   logic      pop;
   logic      full;
   logic      not_empty;
   entry_type head;

   otl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .queue_full (full),
      .push       (push),
      .push_entry (push_entry)
   );

   otl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (full),
      .not_empty  (not_empty),
      .head       (head)
   );

   otl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .not_empty (not_empty),
      .head      (head),
      .pop       (pop),
      .rsp_if    (rsp_if)
   );

endmodule
`default_nettype wire
